@@ hdl/hsv_to_rgb_converter_core_assert.svh @@
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Property forms for the converter checker, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// The consequent must hold in every cycle in which the antecedent holds.
`define H2R_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be seen.
`define H2R_ASSERT_NEVER(lbl, bad, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(bad)) \
        else $error(msg);

`endif

@@ hdl/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Pipeline latency and the hue sector codes shared by the converter files.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

    // Cycles from an accepted item to its result strobe.
    localparam int LATENCY = 10;

    // Sixty-degree hue sectors, named by the colors at their two ends.
    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } t_sector;

endpackage

`default_nettype wire

@@ hdl/hsv_to_rgb_converter_core.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Converts one hue/saturation/value/alpha pixel per clock into RGB plus alpha.
// ----------------------------------------------------------------------------
// The core takes one pixel in every clock cycle and never raises busy. Each
// result appears on the output ports for a single cycle with o_strobe high;
// the receiver must accept it then, since there is no way to hold results
// back. Results pass through a ten-register pipeline that performs the four
// divisions by constants (hue by the full turn and the sector width, chroma
// by the channel maximum, and the intermediate by the sector width) as
// reciprocal multiplies, each followed by a registered remainder check and a
// one-step correction.
`default_nettype none

module hsv_to_rgb_converter_core
    import hsvrgb_pkg::*;
#(
    parameter int HUE_FRAC_BITS = 6,
    parameter int CHANNEL_BITS  = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [15:0]             i_hue,
    input  wire logic [CHANNEL_BITS-1:0] i_saturation,
    input  wire logic [CHANNEL_BITS-1:0] i_brightness,
    input  wire logic [7:0]              i_alpha_in,
    output logic                         o_strobe,
    output logic [CHANNEL_BITS-1:0]      o_red,
    output logic [CHANNEL_BITS-1:0]      o_green,
    output logic [CHANNEL_BITS-1:0]      o_blue,
    output logic [7:0]                   o_alpha_out
);

    localparam int CB   = CHANNEL_BITS;
    localparam int HW   = 16;
    localparam int CMAX = (1 << CB) - 1;
    localparam int SW   = 60 << HUE_FRAC_BITS;
    localparam int FT   = 360 << HUE_FRAC_BITS;
    localparam int SWW  = $clog2(SW + 1);

    // Hue modulo the full turn.
    localparam longint unsigned R_T = (64'd1 << HW) / FT;
    localparam int RT_W = (R_T > 0) ? $clog2(R_T + 1) : 1;
    localparam int TPW  = HW + RT_W;

    // Chroma: round(v*s/CMAX) as floor((2vs + CMAX) / (2 CMAX)).
    localparam int KC   = 2 * CB + 1;
    localparam int DC   = 2 * CMAX;
    localparam longint unsigned R_C = (64'd1 << KC) / DC;
    localparam int RC_W = $clog2(R_C + 1);
    localparam int CPW  = KC + RC_W;
    localparam int CRW  = CB + 2;

    // Sector and remainder inside the sector.
    localparam longint unsigned R_S = (64'd1 << HW) / SW;
    localparam int RS_W = $clog2(R_S + 1);
    localparam int SPW  = HW + RS_W;

    // Intermediate: round(c*t/SW) as floor((2ct + SW) / (2 SW)).
    localparam int KX   = CB + SWW + 1;
    localparam int DX   = 2 * SW;
    localparam longint unsigned R_X = (64'd1 << KX) / DX;
    localparam int RX_W = $clog2(R_X + 1);
    localparam int XPW  = KX + RX_W;
    localparam int XRW  = SWW + 2;

    logic [LATENCY-1:0] r_vld, n_vld;

    // Stage A
    logic [TPW-1:0]  r_a_tprod;
    logic [2*CB-1:0] r_a_vs;
    logic [HW-1:0]   r_a_hue;
    logic [CB-1:0]   r_a_v;
    logic [7:0]      r_a_alpha;
    // Stage B
    logic [HW-1:0]   r_b_h0, n_b_h0;
    logic [KC-1:0]   r_b_cnum, n_b_cnum;
    logic [CPW-1:0]  r_b_cprod;
    logic [CB-1:0]   r_b_v;
    logic [7:0]      r_b_alpha;
    // Stage C
    logic [HW-1:0]   r_c_h, n_c_h;
    logic [CB-1:0]   r_c_cq0;
    logic [CRW-1:0]  r_c_crem, n_c_crem;
    logic [CB-1:0]   r_c_v;
    logic [7:0]      r_c_alpha;
    // Stage D
    logic [HW-1:0]   r_d_h;
    logic [SPW-1:0]  r_d_sprod;
    logic [CB-1:0]   r_d_c, n_d_c;
    logic [CB-1:0]   r_d_v;
    logic [7:0]      r_d_alpha;
    // Stage E
    logic [2:0]      r_e_sq0;
    logic [SWW:0]    r_e_srem0, n_e_srem0;
    logic [CB-1:0]   r_e_c;
    logic [CB-1:0]   r_e_m;
    logic [7:0]      r_e_alpha;
    // Stage F
    t_sector         r_f_sector, n_f_sector;
    logic [SWW-1:0]  r_f_rem, n_f_rem;
    logic [CB-1:0]   r_f_c;
    logic [CB-1:0]   r_f_m;
    logic [7:0]      r_f_alpha;
    // Stage G
    logic [CB+SWW-1:0] r_g_ct;
    logic [SWW-1:0]  n_g_t;
    t_sector         r_g_sector;
    logic [CB-1:0]   r_g_c;
    logic [CB-1:0]   r_g_m;
    logic [7:0]      r_g_alpha;
    // Stage H
    logic [KX-1:0]   r_h_xnum, n_h_xnum;
    logic [XPW-1:0]  r_h_xprod;
    t_sector         r_h_sector;
    logic [CB-1:0]   r_h_c;
    logic [CB-1:0]   r_h_m;
    logic [7:0]      r_h_alpha;
    // Stage I
    logic [CB-1:0]   r_i_xq0;
    logic [XRW-1:0]  r_i_xrem, n_i_xrem;
    t_sector         r_i_sector;
    logic [CB-1:0]   r_i_c;
    logic [CB-1:0]   r_i_m;
    logic [7:0]      r_i_alpha;
    // Stage J (outputs)
    logic [CB-1:0]   r_red, n_red;
    logic [CB-1:0]   r_green, n_green;
    logic [CB-1:0]   r_blue, n_blue;
    logic [7:0]      r_alpha;

    // Combinational helpers
    logic [RT_W-1:0] w_qt;
    logic [31:0]     w_h0_full;
    logic [CB-1:0]   w_cq0;
    logic [KC-1:0]   w_crem_full;
    logic [2:0]      w_sq0;
    logic [HW-1:0]   w_srem_full;
    logic [CB-1:0]   w_xq0;
    logic [KX-1:0]   w_xrem_full;
    logic [CB-1:0]   w_x;
    logic [CB-1:0]   w_r, w_g, w_b;

    assign busy = 1'b0;
    assign n_vld = {r_vld[LATENCY-2:0], start & ~busy};

    always_comb begin
        // Stage B: first hue reduction, chroma numerator and reciprocal product.
        w_qt      = r_a_tprod[TPW-1:HW];
        w_h0_full = 32'(r_a_hue) - 32'(w_qt) * 32'(FT);
        n_b_h0    = w_h0_full[HW-1:0];
        n_b_cnum  = KC'({r_a_vs, 1'b0}) + KC'(CMAX);

        // Stage C: finish hue reduction, chroma quotient estimate and remainder.
        n_c_h       = (32'(r_b_h0) >= 32'(FT)) ? HW'(32'(r_b_h0) - 32'(FT)) : r_b_h0;
        w_cq0       = r_b_cprod[KC +: CB];
        w_crem_full = r_b_cnum - KC'(w_cq0) * KC'(DC);
        n_c_crem    = w_crem_full[CRW-1:0];

        // Stage D: chroma correction.
        n_d_c = (r_c_crem >= CRW'(DC)) ? r_c_cq0 + CB'(1) : r_c_cq0;

        // Stage E: sector estimate and its remainder.
        w_sq0       = r_d_sprod[HW +: 3];
        w_srem_full = r_d_h - HW'(w_sq0) * HW'(SW);
        n_e_srem0   = w_srem_full[SWW:0];

        // Stage F: sector correction.
        if (r_e_srem0 >= (SWW+1)'(SW)) begin
            n_f_sector = t_sector'(r_e_sq0 + 3'd1);
            n_f_rem    = SWW'(r_e_srem0 - (SWW+1)'(SW));
        end else begin
            n_f_sector = t_sector'(r_e_sq0);
            n_f_rem    = SWW'(r_e_srem0);
        end

        // Stage G: odd sectors ramp down across the sector.
        if (r_f_sector == SEC_YELLOW_GREEN || r_f_sector == SEC_CYAN_BLUE ||
                r_f_sector == SEC_MAGENTA_RED) begin
            n_g_t = SWW'(SW) - r_f_rem;
        end else begin
            n_g_t = r_f_rem;
        end

        // Stage H: intermediate numerator.
        n_h_xnum = KX'({r_g_ct, 1'b0}) + KX'(SW);

        // Stage I: intermediate quotient estimate and remainder.
        w_xq0       = r_h_xprod[KX +: CB];
        w_xrem_full = r_h_xnum - KX'(w_xq0) * KX'(DX);
        n_i_xrem    = w_xrem_full[XRW-1:0];

        // Stage J: correction, channel placement and offset.
        w_x = (r_i_xrem >= XRW'(DX)) ? r_i_xq0 + CB'(1) : r_i_xq0;
        unique case (r_i_sector)
            SEC_RED_YELLOW: begin
                w_r = r_i_c; w_g = w_x;   w_b = '0;
            end
            SEC_YELLOW_GREEN: begin
                w_r = w_x;   w_g = r_i_c; w_b = '0;
            end
            SEC_GREEN_CYAN: begin
                w_r = '0;    w_g = r_i_c; w_b = w_x;
            end
            SEC_CYAN_BLUE: begin
                w_r = '0;    w_g = w_x;   w_b = r_i_c;
            end
            SEC_BLUE_MAGENTA: begin
                w_r = w_x;   w_g = '0;    w_b = r_i_c;
            end
            SEC_MAGENTA_RED: begin
                w_r = r_i_c; w_g = '0;    w_b = w_x;
            end
            default: begin
                w_r = r_i_c; w_g = '0;    w_b = w_x;
            end
        endcase
        n_red   = w_r + r_i_m;
        n_green = w_g + r_i_m;
        n_blue  = w_b + r_i_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_tprod  <= TPW'(i_hue) * TPW'(R_T);
        r_a_vs     <= (2*CB)'(i_saturation) * (2*CB)'(i_brightness);
        r_a_hue    <= i_hue;
        r_a_v      <= i_brightness;
        r_a_alpha  <= i_alpha_in;

        r_b_h0     <= n_b_h0;
        r_b_cnum   <= n_b_cnum;
        r_b_cprod  <= CPW'(n_b_cnum) * CPW'(R_C);
        r_b_v      <= r_a_v;
        r_b_alpha  <= r_a_alpha;

        r_c_h      <= n_c_h;
        r_c_cq0    <= w_cq0;
        r_c_crem   <= n_c_crem;
        r_c_v      <= r_b_v;
        r_c_alpha  <= r_b_alpha;

        r_d_h      <= r_c_h;
        r_d_sprod  <= SPW'(r_c_h) * SPW'(R_S);
        r_d_c      <= n_d_c;
        r_d_v      <= r_c_v;
        r_d_alpha  <= r_c_alpha;

        r_e_sq0    <= w_sq0;
        r_e_srem0  <= n_e_srem0;
        r_e_c      <= r_d_c;
        r_e_m      <= r_d_v - r_d_c;
        r_e_alpha  <= r_d_alpha;

        r_f_sector <= n_f_sector;
        r_f_rem    <= n_f_rem;
        r_f_c      <= r_e_c;
        r_f_m      <= r_e_m;
        r_f_alpha  <= r_e_alpha;

        r_g_ct     <= (CB+SWW)'(r_f_c) * (CB+SWW)'(n_g_t);
        r_g_sector <= r_f_sector;
        r_g_c      <= r_f_c;
        r_g_m      <= r_f_m;
        r_g_alpha  <= r_f_alpha;

        r_h_xnum   <= n_h_xnum;
        r_h_xprod  <= XPW'(n_h_xnum) * XPW'(R_X);
        r_h_sector <= r_g_sector;
        r_h_c      <= r_g_c;
        r_h_m      <= r_g_m;
        r_h_alpha  <= r_g_alpha;

        r_i_xq0    <= w_xq0;
        r_i_xrem   <= n_i_xrem;
        r_i_sector <= r_h_sector;
        r_i_c      <= r_h_c;
        r_i_m      <= r_h_m;
        r_i_alpha  <= r_h_alpha;

        r_red      <= n_red;
        r_green    <= n_green;
        r_blue     <= n_blue;
        r_alpha    <= r_i_alpha;
    end

    assign o_strobe    = r_vld[LATENCY-1];
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_alpha_out = r_alpha;

endmodule

`default_nettype wire

@@ hdl/hsvrgb_checker.sv @@
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level properties of the converter, bound to every instance of the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_converter_core_assert.svh"

module hsvrgb_checker
    import hsvrgb_pkg::*;
#(
    parameter int CHANNEL_BITS = 8
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic [CHANNEL_BITS-1:0] i_saturation,
    input wire logic [CHANNEL_BITS-1:0] i_brightness,
    input wire logic [7:0]              i_alpha_in,
    input wire logic                    o_strobe,
    input wire logic [CHANNEL_BITS-1:0] o_red,
    input wire logic [CHANNEL_BITS-1:0] o_green,
    input wire logic [CHANNEL_BITS-1:0] o_blue,
    input wire logic [7:0]              o_alpha_out
);

    // Brightness and a grey flag delayed to line up with the result strobe.
    logic [CHANNEL_BITS-1:0] r_v_pipe [LATENCY];
    logic [LATENCY-1:0]      r_grey_pipe;
    logic [CHANNEL_BITS-1:0] w_v;

    always_ff @(posedge i_clk) begin
        r_v_pipe[0]    <= i_brightness;
        r_grey_pipe[0] <= (i_saturation == '0);
        for (int k = 1; k < LATENCY; k++) begin
            r_v_pipe[k]    <= r_v_pipe[k-1];
            r_grey_pipe[k] <= r_grey_pipe[k-1];
        end
    end

    assign w_v = r_v_pipe[LATENCY-1];

    `H2R_ASSERT_IMPLY(a_strobe_source, o_strobe, $past(start && !busy, LATENCY), "result without an item")
    `H2R_ASSERT_IMPLY(a_alpha_copy, o_strobe, o_alpha_out == $past(i_alpha_in, LATENCY), "alpha changed")
    `H2R_ASSERT_IMPLY(a_grey, o_strobe && r_grey_pipe[LATENCY-1], o_red == w_v && o_green == w_v && o_blue == w_v, "grey pixel not grey")
    `H2R_ASSERT_NEVER(a_bound, o_strobe && (o_red > w_v || o_green > w_v || o_blue > w_v), "channel above value")
    `H2R_ASSERT_IMPLY(a_peak, o_strobe, o_red == w_v || o_green == w_v || o_blue == w_v, "no channel at value")

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker #(
    .CHANNEL_BITS(CHANNEL_BITS)
) u_hsvrgb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_saturation (i_saturation),
    .i_brightness (i_brightness),
    .i_alpha_in   (i_alpha_in),
    .o_strobe     (o_strobe),
    .o_red        (o_red),
    .o_green      (o_green),
    .o_blue       (o_blue),
    .o_alpha_out  (o_alpha_out)
);

`default_nettype wire
